// ----- src/stb_pkg.sv -----
// Package for the software timer bank: operation codes and tick counter constants.
`timescale 1ns / 1ps
package stb_pkg;

  localparam int FUNC_W = 3;
  localparam int ID_W   = 8;
  localparam int PER_W  = 32;
  localparam int RUN_W  = 31;

  localparam logic [FUNC_W-1:0] OP_TICK       = 3'd0;
  localparam logic [FUNC_W-1:0] OP_START_ONCE = 3'd1;
  localparam logic [FUNC_W-1:0] OP_START_AUTO = 3'd2;
  localparam logic [FUNC_W-1:0] OP_STOP       = 3'd3;
  localparam logic [FUNC_W-1:0] OP_CHECK      = 3'd4;
  localparam logic [FUNC_W-1:0] OP_RELOAD     = 3'd5;

  // The tick counter never shows this value; it wraps to zero instead.
  localparam logic [RUN_W-1:0] RUN_WRAP = 31'h7FFF_FFFF;

endpackage

// ----- src/soft_timer_bank_core.sv -----
// Top level of the software timer bank: one memory of timer entries and its sequencer.
`timescale 1ns / 1ps
// A bank of TIMERS down-counting timers sharing one tick counter that advances on each tick.
// Each input beat (in_func, in_timer_id, in_period) is one operation: tick,
// start one-shot, start auto-reload, stop, check or reload. Every input beat
// produces exactly one output beat (out_expired, out_run_time, out_bad_id).
// Both channels use valid/ready; a beat moves when valid and ready are high.
//
// Timer state lives in one memory entry per timer with a registered read.
// An addressed operation reads its entry, modifies it and writes it back,
// then hands its result to the output register from the finishing state;
// the next beat is taken once the sequencer is idle again. A tick sweeps all
// entries, one per cycle, with the read of the next entry overlapped with
// the write-back of the current one, and then finishes the same way. A bad
// id or an unused code goes straight to the finishing state and answers
// without touching memory.
// One operation is in flight at a time; in_ready is high while idle, even
// when a finished result still sits in the output register.
//
// Synchronous reset clears the tick counter and one valid bit per entry; an
// entry whose valid bit is clear reads as all zero, so no clearing pass is
// needed. When the receiver stalls, the finished result waits for the output
// register to drain and the next input is held off until then.
module soft_timer_bank_core
  import stb_pkg::*;
#(
  parameter int TIMERS      = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [ID_W-1:0]  in_timer_id,
  input  logic [PER_W-1:0] in_period,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_expired,
  output logic [RUN_W-1:0] out_run_time,
  output logic             out_bad_id
);

  localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int ENT_W = 2 * COUNT_WIDTH + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMERS - 1);
  localparam logic [ID_W:0]    TIMERS_CMP = (ID_W + 1)'(TIMERS);

  // Entry layout: remaining count, preload, expired flag, auto mode.
  localparam int REM_LO  = 0;
  localparam int RLD_LO  = COUNT_WIDTH;
  localparam int FLAG_B  = 2 * COUNT_WIDTH;
  localparam int AUTO_B  = 2 * COUNT_WIDTH + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_OP   = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [FUNC_W-1:0]      func_r, func_nxt;
  logic [COUNT_WIDTH-1:0] per_r, per_nxt;
  logic [IDX_W-1:0]       wa_r, wa_nxt;
  logic                   res_exp_r, res_exp_nxt;
  logic                   res_bad_r, res_bad_nxt;
  logic [RUN_W-1:0]       tick_r, tick_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_exp_r, out_exp_nxt;
  logic                   out_bad_r, out_bad_nxt;
  logic [RUN_W-1:0]       out_run_r, out_run_nxt;
  logic [TIMERS-1:0]      vld_r;

  logic [ENT_W-1:0] mem [TIMERS];
  logic [ENT_W-1:0] rd_data_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [ENT_W-1:0] wr_data;

  logic             in_fire;
  logic             out_free;
  logic             id_bad;
  logic [ENT_W-1:0] ent;
  logic [COUNT_WIDTH-1:0] cur_rem, cur_rld, dec_rem;
  logic             cur_flag, cur_auto;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign id_bad   = ({1'b0, in_timer_id} >= TIMERS_CMP);

  // An entry never written since reset reads as all zero.
  assign ent      = rd_vld_r ? rd_data_r : '0;
  assign cur_rem  = ent[REM_LO +: COUNT_WIDTH];
  assign cur_rld  = ent[RLD_LO +: COUNT_WIDTH];
  assign cur_flag = ent[FLAG_B];
  assign cur_auto = ent[AUTO_B];
  assign dec_rem  = cur_rem - COUNT_WIDTH'(1);

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    per_nxt       = per_r;
    wa_nxt        = wa_r;
    res_exp_nxt   = res_exp_r;
    res_bad_nxt   = res_bad_r;
    tick_nxt      = tick_r;
    out_valid_nxt = out_valid_r;
    out_exp_nxt   = out_exp_r;
    out_bad_nxt   = out_bad_r;
    out_run_nxt   = out_run_r;
    rd_addr       = in_timer_id[IDX_W-1:0];
    mem_we        = 1'b0;
    wr_data       = ent;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          func_nxt    = in_func;
          per_nxt     = COUNT_WIDTH'(in_period);
          wa_nxt      = in_timer_id[IDX_W-1:0];
          res_exp_nxt = 1'b0;
          res_bad_nxt = 1'b0;
          if (in_func == OP_TICK) begin
            // The counter advances now; the sweep finishes before the result leaves.
            rd_addr   = '0;
            wa_nxt    = '0;
            state_nxt = S_TICK;
            tick_nxt  = (tick_r == RUN_WRAP - RUN_W'(1)) ? '0 : tick_r + RUN_W'(1);
          end else if (in_func > OP_RELOAD) begin
            state_nxt = S_DONE;
          end else if (id_bad) begin
            res_bad_nxt = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_OP;
          end
        end
      end
      S_TICK: begin
        mem_we = 1'b1;
        if (cur_rem != '0) begin
          if (dec_rem == '0) begin
            wr_data[FLAG_B] = 1'b1;
            wr_data[REM_LO +: COUNT_WIDTH] = cur_auto ? cur_rld : '0;
          end else begin
            wr_data[REM_LO +: COUNT_WIDTH] = dec_rem;
          end
        end
        // Read of the next entry overlaps the write-back of this one.
        rd_addr = wa_r + IDX_W'(1);
        if (wa_r == LAST_IDX) begin
          state_nxt = S_DONE;
        end else begin
          wa_nxt = wa_r + IDX_W'(1);
        end
      end
      S_OP: begin
        mem_we    = 1'b1;
        state_nxt = S_DONE;
        case (func_r)
          OP_START_ONCE, OP_START_AUTO: begin
            wr_data[REM_LO +: COUNT_WIDTH] = per_r;
            wr_data[RLD_LO +: COUNT_WIDTH] = per_r;
            wr_data[FLAG_B] = 1'b0;
            wr_data[AUTO_B] = (func_r == OP_START_AUTO);
          end
          OP_STOP: begin
            wr_data[REM_LO +: COUNT_WIDTH] = '0;
            wr_data[FLAG_B] = 1'b0;
            wr_data[AUTO_B] = 1'b0;
          end
          OP_CHECK: begin
            res_exp_nxt     = cur_flag;
            wr_data[FLAG_B] = 1'b0;
          end
          OP_RELOAD: begin
            wr_data[REM_LO +: COUNT_WIDTH] = cur_rld;
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end
      default: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_exp_nxt   = res_exp_r;
          out_bad_nxt   = res_bad_r;
          out_run_nxt   = tick_r;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  // Timer entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wa_r] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) begin
        vld_r[wa_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    per_r     <= per_nxt;
    wa_r      <= wa_nxt;
    res_exp_r <= res_exp_nxt;
    res_bad_r <= res_bad_nxt;
    out_exp_r <= out_exp_nxt;
    out_bad_r <= out_bad_nxt;
    out_run_r <= out_run_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_expired  = out_exp_r;
  assign out_bad_id   = out_bad_r;
  assign out_run_time = out_run_r;

  // The memory is never written while the sequencer is idle or finishing.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !mem_we)
    else $error("timer memory written outside an operation");

  // A new result only ever comes from the finishing state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside the finishing state");

  // The tick counter moves only when a tick is accepted.
  a_tick_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && in_func == OP_TICK) |=> $stable(tick_r))
    else $error("tick counter changed without a tick");

endmodule
